/* rtl/assert_macros.svh */
// Assertion macros used by the sequencer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

/* rtl/sles_pkg.sv */
// Types and constants of the status lamp effect sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sles_pkg;

   typedef enum logic [2:0] {
      FX_NONE       = 3'd0,
      FX_FAULT      = 3'd1,
      FX_HEARTBEAT  = 3'd2,
      FX_ATTACHED   = 3'd3,
      FX_REMOVED    = 3'd4,
      FX_BUSY       = 3'd5,
      FX_BUSY_SHORT = 3'd6,
      FX_WELCOME    = 3'd7
   } effect_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic lamp;
      logic done;
   } step_type;

   localparam int ELAPSED_W = 10;
   localparam int IDLE_W    = 12;
   localparam int MOD_W     = 4;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 10'd1023;
   localparam logic [IDLE_W-1:0]    IDLE_MAX    = 12'd4095;
   localparam logic [IDLE_W-1:0]    IDLE_THRESHOLD_RESET = 12'd2940;
   localparam logic [MOD_W-1:0]     IDLE_MOD_LAST = 4'd9;

   localparam logic [ELAPSED_W-1:0] HB_END         = 10'd50;
   localparam logic [ELAPSED_W-1:0] ATT_OFF        = 10'd100;
   localparam logic [ELAPSED_W-1:0] ATT_ON         = 10'd250;
   localparam logic [ELAPSED_W-1:0] ATT_END        = 10'd750;
   localparam logic [ELAPSED_W-1:0] REM_OFF        = 10'd500;
   localparam logic [ELAPSED_W-1:0] REM_ON         = 10'd650;
   localparam logic [ELAPSED_W-1:0] REM_END        = 10'd750;
   localparam logic [ELAPSED_W-1:0] WEL_OFF        = 10'd200;
   localparam logic [ELAPSED_W-1:0] WEL_ON         = 10'd300;
   localparam logic [ELAPSED_W-1:0] WEL_END        = 10'd500;
   localparam logic [ELAPSED_W-1:0] BUSY_END       = 10'd400;
   localparam logic [ELAPSED_W-1:0] BUSY_SHORT_END = 10'd200;
   localparam logic [ELAPSED_W-1:0] BUSY_PERIOD    = 10'd100;
   localparam logic [ELAPSED_W-1:0] BUSY_DARK      = 10'd20;

endpackage

`default_nettype wire

/* rtl/status_led_effect_sequencer_core.sv */
// Status lamp effect sequencer: input stage, state update and result register.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata : cmd[1:0], effect_code[4:2]
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata : lamp[0], current_effect[3:1]
//  csr     | in  | csr_wen              | csr_wdata : idle_threshold[11:0]
//
// One item per cycle sustained while rsp_tready is high; an item taken into the input
// stage reaches the result register via the lamp, effect, elapsed and idle update.
// Synchronous active-high reset clears the stages and all state, threshold to 2940.
// A stalled result holds in the result register while the input stage keeps its item.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module status_led_effect_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // cmd[1:0], effect_code[4:2]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // lamp[0], current_effect[3:1]
   input  wire logic        csr_wen,
   input  wire logic [11:0] csr_wdata
);

   logic                                 in_valid_ff;
   logic [1:0]                           in_cmd_ff;
   logic [2:0]                           in_code_ff;
   logic                                 out_valid_ff;
   logic                                 out_lamp_ff;
   sles_pkg::effect_type                 out_effect_ff;

   logic [sles_pkg::IDLE_W-1:0]          thr_ff;
   logic                                 lamp_ff, lamp_in;
   sles_pkg::effect_type                 act_ff, act_in;
   logic [sles_pkg::ELAPSED_W-1:0]       el_ff, el_in;
   logic [sles_pkg::IDLE_W-1:0]          idle_ff, idle_in;
   logic [sles_pkg::MOD_W-1:0]           mod_ff, mod_in;

   logic                                 out_free;
   logic                                 advance;
   sles_pkg::step_type                   step;
   sles_pkg::effect_type                 code;

   function automatic sles_pkg::step_type four_step(
      input logic [sles_pkg::ELAPSED_W-1:0] t,
      input logic [sles_pkg::ELAPSED_W-1:0] off1,
      input logic [sles_pkg::ELAPSED_W-1:0] on2,
      input logic [sles_pkg::ELAPSED_W-1:0] stop_at,
      input logic                           lamp
   );
      sles_pkg::step_type s;
      s.lamp = lamp;
      s.done = 1'b0;
      if (t == '0) begin
         s.lamp = 1'b1;
      end else if (t == off1) begin
         s.lamp = 1'b0;
      end else if (t == on2) begin
         s.lamp = 1'b1;
      end else if (t == stop_at) begin
         s.done = 1'b1;
      end
      return s;
   endfunction

   function automatic sles_pkg::step_type busy_step(
      input logic [sles_pkg::ELAPSED_W-1:0] t,
      input logic [sles_pkg::ELAPSED_W-1:0] stop_at,
      input logic                           lamp
   );
      sles_pkg::step_type s;
      logic [sles_pkg::ELAPSED_W-1:0] p;
      p = sles_pkg::BUSY_PERIOD;
      s.lamp = lamp;
      s.done = 1'b0;
      // below the end point t stays under four periods
      if (t >= stop_at) begin
         s.done = 1'b1;
      end else if (t == '0 || t == p || t == 10'(2 * p) || t == 10'(3 * p)) begin
         s.lamp = 1'b1;
      end else if (t == sles_pkg::BUSY_DARK || t == 10'(sles_pkg::BUSY_DARK + p)
                   || t == 10'(sles_pkg::BUSY_DARK + 2 * p)
                   || t == 10'(sles_pkg::BUSY_DARK + 3 * p)) begin
         s.lamp = 1'b0;
      end
      return s;
   endfunction

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign code       = sles_pkg::effect_type'(in_code_ff);

   always_comb begin
      lamp_in = lamp_ff;
      act_in  = act_ff;
      el_in   = el_ff;
      idle_in = idle_ff;
      mod_in  = mod_ff;
      step    = '{lamp: lamp_ff, done: 1'b0};
      case (sles_pkg::cmd_type'(in_cmd_ff))
         sles_pkg::CMD_TICK: begin
            if (act_in == sles_pkg::FX_NONE) begin
               if (idle_in != sles_pkg::IDLE_MAX) begin
                  idle_in = idle_in + 12'd1;
                  mod_in  = (mod_in == sles_pkg::IDLE_MOD_LAST) ? '0 : mod_in + 4'd1;
               end
               if (idle_in > thr_ff && mod_in == '0) begin
                  act_in = sles_pkg::FX_HEARTBEAT;
                  el_in  = '0;
               end
            end
            if (act_in != sles_pkg::FX_NONE) begin
               idle_in = '0;
               mod_in  = '0;
               case (act_in)
                  sles_pkg::FX_HEARTBEAT: begin
                     if (el_in == '0) begin
                        step.lamp = 1'b1;
                     end else if (el_in == sles_pkg::HB_END) begin
                        step.done = 1'b1;
                     end
                  end
                  sles_pkg::FX_ATTACHED: begin
                     step = four_step(el_in, sles_pkg::ATT_OFF, sles_pkg::ATT_ON,
                                      sles_pkg::ATT_END, lamp_in);
                  end
                  sles_pkg::FX_REMOVED: begin
                     step = four_step(el_in, sles_pkg::REM_OFF, sles_pkg::REM_ON,
                                      sles_pkg::REM_END, lamp_in);
                  end
                  sles_pkg::FX_WELCOME: begin
                     step = four_step(el_in, sles_pkg::WEL_OFF, sles_pkg::WEL_ON,
                                      sles_pkg::WEL_END, lamp_in);
                  end
                  sles_pkg::FX_BUSY: begin
                     step = busy_step(el_in, sles_pkg::BUSY_END, lamp_in);
                  end
                  sles_pkg::FX_BUSY_SHORT: begin
                     step = busy_step(el_in, sles_pkg::BUSY_SHORT_END, lamp_in);
                  end
                  default: begin
                     step = '{lamp: lamp_in, done: 1'b0};
                  end
               endcase
               lamp_in = step.lamp;
               if (step.done) begin
                  lamp_in = 1'b0;
                  act_in  = sles_pkg::FX_NONE;
               end
               if (el_in != sles_pkg::ELAPSED_MAX) begin
                  el_in = el_in + 10'd1;
               end
            end
         end
         sles_pkg::CMD_START: begin
            if (code == sles_pkg::FX_FAULT) begin
               lamp_in = 1'b1;
            end
            if (!((code == sles_pkg::FX_BUSY && act_ff == sles_pkg::FX_BUSY_SHORT) ||
                  (code == sles_pkg::FX_BUSY_SHORT && act_ff == sles_pkg::FX_BUSY))) begin
               act_in = code;
               el_in  = '0;
            end
         end
         sles_pkg::CMD_STOP: begin
            if (act_ff == code) begin
               lamp_in = 1'b0;
               act_in  = sles_pkg::FX_NONE;
               idle_in = '0;
               mod_in  = '0;
            end
         end
         default: begin
            lamp_in = lamp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thr_ff       <= sles_pkg::IDLE_THRESHOLD_RESET;
         lamp_ff      <= 1'b0;
         act_ff       <= sles_pkg::FX_NONE;
         el_ff        <= '0;
         idle_ff      <= '0;
         mod_ff       <= '0;
      end else begin
         if (csr_wen) begin
            thr_ff <= csr_wdata;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            lamp_ff <= lamp_in;
            act_ff  <= act_in;
            el_ff   <= el_in;
            idle_ff <= idle_in;
            mod_ff  <= mod_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tdata[1:0];
         in_code_ff <= req_tdata[4:2];
      end
      if (advance) begin
         out_lamp_ff   <= lamp_in;
         out_effect_ff <= act_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_effect_ff, out_lamp_ff};

   `ASSERT_ALWAYS(a_mod_range, clock, reset, mod_ff <= sles_pkg::IDLE_MOD_LAST,
                  "idle residue out of range")
   `ASSERT_CLKD(a_hb_window, clock, reset,
                act_ff == sles_pkg::FX_HEARTBEAT |-> el_ff <= sles_pkg::HB_END,
                "heartbeat ran past its end point")
   `ASSERT_CLKD(a_in_hold, clock, reset, in_valid_ff && !out_free |=> in_valid_ff,
                "input stage dropped a stalled item")
   `ASSERT_CLKD(a_adv_result, clock, reset, advance |=> out_valid_ff,
                "result register missed an advancing item")

endmodule

`default_nettype wire
